[rtl/tvxz_pkg.sv]
// ============================================================================
// tvxz_pkg: shared types and constants for the vertex XZ half-extent block
// Coordinate formats, configuration register indexes, the transformed item
// that travels from the transform front end to the reduction back end, and
// the world-coordinate saturation function.
// ============================================================================
package tvxz_pkg;

    localparam int COORD_W   = 32;                 // signed fixed-point coordinate width
    localparam int FRAC_W    = 16;                 // fraction bits of the coordinate format
    localparam int RAD_W     = COORD_W - 1;        // unsigned radius width
    localparam int PROD_W    = 2 * COORD_W;        // one full product
    localparam int SUM_W     = 2 * COORD_W + 2;    // three products plus offset, exact

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    // Queue between the transform front end and the reduction back end.
    localparam int MID_DEPTH = 8;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

    // Result queue at the output of the back end.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam t_coord CFG_ONE   = t_coord'(1) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_CX  = 3'd0,
        CFG_X_CY  = 3'd1,
        CFG_X_CZ  = 3'd2,
        CFG_X_OFF = 3'd3,
        CFG_Z_CX  = 3'd4,
        CFG_Z_CY  = 3'd5,
        CFG_Z_CZ  = 3'd6,
        CFG_Z_OFF = 3'd7
    } t_cfg_idx;

    // One transformed item as seen by the back end.
    typedef struct packed {
        logic   no_geom;
        logic   last;
        logic   sat;
        t_coord wx;
        t_coord wz;
    } t_xf_item;

    // One finished result.
    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic             saturated;
    } t_result;

    typedef struct packed {
        logic   sat;
        t_coord val;
    } t_sat_res;

    // Arithmetic shift right by the fraction width, then clamp to the
    // coordinate range.
    function automatic t_sat_res sat_world(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0]     sh;
        logic [SUM_W-COORD_W:0]      hi;
        t_sat_res                    r;
        sh = sum >>> FRAC_W;
        hi = sh[SUM_W-1:COORD_W-1];
        if ((&hi) || (~|hi)) begin
            r.sat = 1'b0;
            r.val = sh[COORD_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = sh[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/tvxz_xform.sv]
// ============================================================================
// tvxz_xform: transform front end
// Holds the model matrix rows and maps each accepted vertex to world x and
// world z in three stages: products, partial sums, final sum and clamp.
// ============================================================================
module tvxz_xform (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tvxz_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  tvxz_pkg::t_coord                 i_cfg_data,
    input  logic                             i_acc,
    input  tvxz_pkg::t_coord                 i_pos_x,
    input  tvxz_pkg::t_coord                 i_pos_y,
    input  tvxz_pkg::t_coord                 i_pos_z,
    input  logic                             i_no_geometry,
    input  logic                             i_last_vertex,
    output logic                             o_vld,
    output tvxz_pkg::t_xf_item               o_item
);

    tvxz_pkg::t_coord                        r_coef [tvxz_pkg::NUM_REGS];

    logic                                    r_s1_vld, r_s2_vld, r_s3_vld;
    logic                                    r_s1_ng, r_s1_last, r_s2_ng, r_s2_last;
    logic signed [tvxz_pkg::PROD_W-1:0]      r_px [3];
    logic signed [tvxz_pkg::PROD_W-1:0]      r_pz [3];
    logic signed [tvxz_pkg::SUM_W-1:0]       r_ax, r_bx, r_az, r_bz;
    tvxz_pkg::t_xf_item                      r_item;
    tvxz_pkg::t_sat_res                      n_sx, n_sz;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tvxz_pkg::NUM_REGS; i++) begin
                if (tvxz_pkg::CFG_IDX_W'(i) == tvxz_pkg::CFG_X_CX ||
                    tvxz_pkg::CFG_IDX_W'(i) == tvxz_pkg::CFG_Z_CZ) begin
                    r_coef[i] <= tvxz_pkg::CFG_ONE;
                end else begin
                    r_coef[i] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_comb begin
        n_sx = tvxz_pkg::sat_world(r_ax + r_bx);
        n_sz = tvxz_pkg::sat_world(r_az + r_bz);
    end

    // Datapath: six products, then two partial sums per row, then the final
    // sum with shift and clamp.
    always_ff @(posedge i_clk) begin
        r_px[0]   <= r_coef[tvxz_pkg::CFG_X_CX] * i_pos_x;
        r_px[1]   <= r_coef[tvxz_pkg::CFG_X_CY] * i_pos_y;
        r_px[2]   <= r_coef[tvxz_pkg::CFG_X_CZ] * i_pos_z;
        r_pz[0]   <= r_coef[tvxz_pkg::CFG_Z_CX] * i_pos_x;
        r_pz[1]   <= r_coef[tvxz_pkg::CFG_Z_CY] * i_pos_y;
        r_pz[2]   <= r_coef[tvxz_pkg::CFG_Z_CZ] * i_pos_z;
        r_s1_ng   <= i_no_geometry;
        r_s1_last <= i_last_vertex;

        r_ax      <= tvxz_pkg::SUM_W'(r_px[0]) + tvxz_pkg::SUM_W'(r_px[1]);
        r_bx      <= tvxz_pkg::SUM_W'(r_px[2]) +
                     (tvxz_pkg::SUM_W'(r_coef[tvxz_pkg::CFG_X_OFF]) <<< tvxz_pkg::FRAC_W);
        r_az      <= tvxz_pkg::SUM_W'(r_pz[0]) + tvxz_pkg::SUM_W'(r_pz[1]);
        r_bz      <= tvxz_pkg::SUM_W'(r_pz[2]) +
                     (tvxz_pkg::SUM_W'(r_coef[tvxz_pkg::CFG_Z_OFF]) <<< tvxz_pkg::FRAC_W);
        r_s2_ng   <= r_s1_ng;
        r_s2_last <= r_s1_last;

        r_item.no_geom <= r_s2_ng;
        r_item.last    <= r_s2_last;
        r_item.sat     <= n_sx.sat | n_sz.sat;
        r_item.wx      <= n_sx.val;
        r_item.wz      <= n_sz.val;
    end

    assign o_vld  = r_s3_vld;
    assign o_item = r_item;

endmodule

[rtl/tvxz_queue.sv]
// ============================================================================
// tvxz_queue: transformed item queue
// Small first-in first-out buffer that decouples the transform front end
// from the reduction back end.
// ============================================================================
module tvxz_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  tvxz_pkg::t_xf_item          i_item,
    input  logic                        i_pop,
    output logic                        o_vld,
    output tvxz_pkg::t_xf_item          o_item
);

    tvxz_pkg::t_xf_item                 r_mem [tvxz_pkg::MID_DEPTH];
    logic [tvxz_pkg::MID_PTR_W-1:0]     r_wr, r_rd;
    logic [tvxz_pkg::MID_CNT_W-1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == tvxz_pkg::MID_PTR_W'(tvxz_pkg::MID_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == tvxz_pkg::MID_PTR_W'(tvxz_pkg::MID_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rd];

endmodule

[rtl/tvxz_reduce.sv]
// ============================================================================
// tvxz_reduce: reduction back end
// Keeps the running bounds of the current run, turns the bounds of a closed
// run into the half-extent result and buffers results for the consumer.
// ============================================================================
module tvxz_reduce (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  tvxz_pkg::t_xf_item              i_item,
    output logic                            o_take,
    input  logic                            i_pop,
    output logic                            o_empty,
    output logic [tvxz_pkg::RAD_W-1:0]      o_radius,
    output logic                            o_saturated
);

    tvxz_pkg::t_coord                       r_min_x, r_max_x, r_min_z, r_max_z;
    logic                                   r_sat_seen;
    tvxz_pkg::t_coord                       n_min_x, n_max_x, n_min_z, n_max_z;
    logic                                   n_close;

    logic                                   r_fin_vld, r_fin_zero, r_fin_sat;
    tvxz_pkg::t_coord                       r_fin_min_x, r_fin_max_x;
    tvxz_pkg::t_coord                       r_fin_min_z, r_fin_max_z;

    logic signed [tvxz_pkg::COORD_W:0]      n_dx, n_dz;
    logic [tvxz_pkg::COORD_W-1:0]           n_ex, n_ez;
    tvxz_pkg::t_result                      n_res;

    tvxz_pkg::t_result                      r_out [tvxz_pkg::OUT_DEPTH];
    logic [tvxz_pkg::OUT_PTR_W-1:0]         r_wr, r_rd;
    logic [tvxz_pkg::OUT_CNT_W-1:0]         r_cnt;
    logic                                   n_out_pop;

    // A queued item is taken only while the result queue has room for every
    // result already on its way.
    assign o_take  = i_vld &&
                     ((tvxz_pkg::OUT_CNT_W + 1)'(r_cnt) +
                      (tvxz_pkg::OUT_CNT_W + 1)'(r_fin_vld) <
                      (tvxz_pkg::OUT_CNT_W + 1)'(tvxz_pkg::OUT_DEPTH));
    assign n_close = i_item.no_geom || i_item.last;

    always_comb begin
        n_min_x = (i_item.wx < r_min_x) ? i_item.wx : r_min_x;
        n_max_x = (i_item.wx > r_max_x) ? i_item.wx : r_max_x;
        n_min_z = (i_item.wz < r_min_z) ? i_item.wz : r_min_z;
        n_max_z = (i_item.wz > r_max_z) ? i_item.wz : r_max_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x    <= tvxz_pkg::COORD_MAX;
            r_max_x    <= tvxz_pkg::COORD_MIN;
            r_min_z    <= tvxz_pkg::COORD_MAX;
            r_max_z    <= tvxz_pkg::COORD_MIN;
            r_sat_seen <= 1'b0;
            r_fin_vld  <= 1'b0;
        end else begin
            r_fin_vld <= o_take && n_close;
            if (o_take) begin
                if (n_close) begin
                    r_min_x    <= tvxz_pkg::COORD_MAX;
                    r_max_x    <= tvxz_pkg::COORD_MIN;
                    r_min_z    <= tvxz_pkg::COORD_MAX;
                    r_max_z    <= tvxz_pkg::COORD_MIN;
                    r_sat_seen <= 1'b0;
                end else begin
                    r_min_x    <= n_min_x;
                    r_max_x    <= n_max_x;
                    r_min_z    <= n_min_z;
                    r_max_z    <= n_max_z;
                    r_sat_seen <= r_sat_seen | i_item.sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && n_close) begin
            r_fin_zero  <= i_item.no_geom;
            r_fin_sat   <= r_sat_seen | i_item.sat;
            r_fin_min_x <= n_min_x;
            r_fin_max_x <= n_max_x;
            r_fin_min_z <= n_min_z;
            r_fin_max_z <= n_max_z;
        end
    end

    // A closed run always holds at least one vertex, so max is not below min
    // and both differences are non-negative.
    always_comb begin
        n_dx = {r_fin_max_x[tvxz_pkg::COORD_W-1], r_fin_max_x} -
               {r_fin_min_x[tvxz_pkg::COORD_W-1], r_fin_min_x};
        n_dz = {r_fin_max_z[tvxz_pkg::COORD_W-1], r_fin_max_z} -
               {r_fin_min_z[tvxz_pkg::COORD_W-1], r_fin_min_z};
        n_ex = n_dx[tvxz_pkg::COORD_W:1];
        n_ez = n_dz[tvxz_pkg::COORD_W:1];
        if (r_fin_zero) begin
            n_res.radius    = '0;
            n_res.saturated = 1'b0;
        end else begin
            n_res.radius    = (n_ex > n_ez) ? n_ex[tvxz_pkg::RAD_W-1:0]
                                            : n_ez[tvxz_pkg::RAD_W-1:0];
            n_res.saturated = r_fin_sat;
        end
    end

    assign n_out_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (r_fin_vld) begin
            r_out[r_wr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_fin_vld) begin
                r_wr <= (r_wr == tvxz_pkg::OUT_PTR_W'(tvxz_pkg::OUT_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (n_out_pop) begin
                r_rd <= (r_rd == tvxz_pkg::OUT_PTR_W'(tvxz_pkg::OUT_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            if (r_fin_vld && !n_out_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!r_fin_vld && n_out_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_empty     = (r_cnt == '0);
    assign o_radius    = r_out[r_rd].radius;
    assign o_saturated = r_out[r_rd].saturated;

endmodule

[rtl/transformed_vertex_xz_half_extent.sv]
// ============================================================================
// transformed_vertex_xz_half_extent: streaming XZ half-extent of a vertex run
// Path: transform stages, item queue, finish register, then result queue.
// Throughput: one vertex per cycle unless full; fully pipelined transform.
// Reset: synchronous, active low; matrix rows return to identity, run
// bounds to empty, and both queues drain to empty.
// ============================================================================
module transformed_vertex_xz_half_extent (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [tvxz_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  tvxz_pkg::t_coord                 i_cfg_data,
    // Vertex input queue side.
    input  logic                             push,
    output logic                             full,
    input  tvxz_pkg::t_coord                 i_pos_x,
    input  tvxz_pkg::t_coord                 i_pos_y,
    input  tvxz_pkg::t_coord                 i_pos_z,
    input  logic                             i_no_geometry,
    input  logic                             i_last_vertex,
    // Result queue side.
    output logic                             empty,
    input  logic                             pop,
    output logic [tvxz_pkg::RAD_W-1:0]       o_radius,
    output logic                             o_saturated
);

    // The front end is a fixed three-stage pipeline with no stall, so every
    // accepted transaction must be guaranteed a slot in the item queue. A
    // credit counter tracks transactions accepted but not yet taken by the
    // back end; the input reports full when all queue slots are spoken for.
    logic                                    n_acc;
    logic                                    xf_vld;
    tvxz_pkg::t_xf_item                      xf_item;
    logic                                    q_vld;
    tvxz_pkg::t_xf_item                      q_item;
    logic                                    q_take;
    logic [tvxz_pkg::MID_CNT_W-1:0]          r_credit;

    assign full  = (r_credit == tvxz_pkg::MID_CNT_W'(tvxz_pkg::MID_DEPTH));
    assign n_acc = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (n_acc && !q_take) begin
            r_credit <= r_credit + 1'b1;
        end else if (!n_acc && q_take) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    // Front end: matrix registers and the world-coordinate pipeline. Every
    // transaction is transformed, including those without geometry; the back
    // end ignores the coordinates of those.
    tvxz_xform u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_acc         (n_acc),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_no_geometry (i_no_geometry),
        .i_last_vertex (i_last_vertex),
        .o_vld         (xf_vld),
        .o_item        (xf_item)
    );

    // Queue between the two halves; the credit counter keeps it from
    // overflowing.
    tvxz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (xf_vld),
        .i_item  (xf_item),
        .i_pop   (q_take),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    // Back end: running bounds, half-extent of each closed run, and the
    // result queue that faces the consumer. It stalls on its own when the
    // consumer stops popping.
    tvxz_reduce u_reduce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (q_vld),
        .i_item      (q_item),
        .o_take      (q_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_radius    (o_radius),
        .o_saturated (o_saturated)
    );

endmodule

[rtl/tvxz_checker.sv]
// ============================================================================
// tvxz_checker: port-level checks for the half-extent block
// Watches the top-level ports only and is attached through a bind statement.
// ============================================================================
module tvxz_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic                             i_no_geometry,
    input  logic                             i_last_vertex,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [tvxz_pkg::RAD_W-1:0]       o_radius,
    input  logic                             o_saturated
);

    // Closing transactions accepted whose results have not yet been popped.
    logic [7:0] r_pending;
    logic       n_close_in, n_res_out;

    assign n_close_in = push && !full && (i_no_geometry || i_last_vertex);
    assign n_res_out  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (n_close_in && !n_res_out) begin
            r_pending <= r_pending + 1'b1;
        end else if (!n_close_in && n_res_out) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // Both queue sides are idle on the edge after any reset edge.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("block not idle after reset");

    // A result is never shown unless a closing transaction is owed one.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pending != 8'd0))
        else $error("result shown with no closing transaction pending");

    // A vertex that neither ends a run nor lacks geometry yields no result.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && r_pending == 8'd0) |=> empty)
        else $error("result appeared with nothing pending");

    // A waiting result holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_radius) && $stable(o_saturated)))
        else $error("waiting result changed before pop");

endmodule

bind transformed_vertex_xz_half_extent tvxz_checker u_tvxz_checker (.*);
